@@ sv/sto_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared codes and default sizes for the sorted timer queue.
// ----------------------------------------------------------------------------
`default_nettype none
package sto_pkg;

   // sizes and reset values
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int OWNER_BITS_DEF  = 12;
   localparam logic [11:0] PRESCALE_RST = 12'd66;
   localparam logic [31:0] PERIOD_RST   = 32'd100000;

   // request operations
   localparam logic [1:0] OP_REGISTER = 2'd0;
   localparam logic [1:0] OP_TICK     = 2'd1;
   localparam logic [1:0] OP_CLEAR    = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;   // ignored, answered with done

   // response kinds
   localparam logic [1:0] KIND_STATUS   = 2'd0;
   localparam logic [1:0] KIND_FIRED    = 2'd1;
   localparam logic [1:0] KIND_PERIODIC = 2'd2;
   localparam logic [1:0] KIND_DONE     = 2'd3;

   // registration status
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DISABLED = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   // control register indexes
   localparam logic [1:0] CSR_ENABLE   = 2'd0;
   localparam logic [1:0] CSR_PRESCALE = 2'd1;
   localparam logic [1:0] CSR_PERIOD   = 2'd2;

endpackage
`default_nettype wire

@@ sv/sto_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered, enable-gated read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sto_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic                                   re,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

@@ sv/sorted_timer_queue.sv @@
// ----------------------------------------------------------------------------
// Sorted timer queue
// Timer table kept sorted by expiry in a circular RAM, 64-bit time base.
// ----------------------------------------------------------------------------
//  channel | direction | tuser      | tdata (low bit up)                  | tlast
//  req_    | in        | operation  | delay, owner                        | -
//  rsp_    | out       | kind       | status, fired_owner, expiry, stamp  | last
//  csr_    | in        | -          | write enable, index, data           | -
//
//  Register: decode, a read and a compare per later entry and for the first
//  one not later, walking from the tail, one more read step when the entry
//  lands at the head, and the write; the request is taken in the idle state.
//  Tick: decode, a read and a compare per fired timer and for the first unexpired
//  entry (only the read if the table runs empty), then a closing step, with a
//  second one for a periodic result after fired timers. Clear and refusals: decode.
//  One result register; the sequencer stalls while it is held by rsp_tready.
//  Reset is synchronous; the table is empty after reset (fill count zero).
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_timer_queue #(
   parameter int QUEUE_DEPTH = sto_pkg::QUEUE_DEPTH_DEF,
   parameter int OWNER_BITS  = sto_pkg::OWNER_BITS_DEF,
   localparam int REQ_W = ((64 + OWNER_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((130 + OWNER_BITS + 7) / 8) * 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [1:0]       req_tuser,   // operation
   input  wire logic [REQ_W-1:0] req_tdata,   // delay, owner
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [1:0]            rsp_tuser,   // kind
   output logic [RSP_W-1:0]      rsp_tdata,   // status, fired_owner, expiry, timestamp
   output logic                  rsp_tlast,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [31:0]      csr_wdata
);

   localparam int AW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = 64 + OWNER_BITS;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DECODE   = 4'd1;
   localparam logic [3:0] S_INS_RD   = 4'd2;
   localparam logic [3:0] S_INS_CMP  = 4'd3;
   localparam logic [3:0] S_INS_PUT  = 4'd4;
   localparam logic [3:0] S_FIRE_RD  = 4'd5;
   localparam logic [3:0] S_FIRE_CMP = 4'd6;
   localparam logic [3:0] S_FIRE_END = 4'd7;

   // circular slot of an offset from the head
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                          input logic [CW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, head} + (AW+1)'(off);
      if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (AW+1)'(QUEUE_DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   logic [3:0]  state_ff, state_in;
   logic        enable_ff;
   logic [11:0] prescale_ff;
   logic [31:0] period_ff;
   logic [63:0] time_ff, time_in;
   logic [11:0] pcount_ff, pcount_in;
   logic [63:0] nextp_ff, nextp_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [1:0]  op_ff;
   logic [63:0] delay_ff;
   logic [OWNER_BITS-1:0] owner_ff;
   logic [63:0] exp_ff, exp_in;
   logic        per_ff, per_in;
   logic        pend_ff, pend_in;
   logic [EW-1:0] pdata_ff, pdata_in;

   logic        rvalid_ff;
   logic [1:0]  rkind_ff;
   logic [1:0]  rstat_ff;
   logic [OWNER_BITS-1:0] rown_ff;
   logic [63:0] rexp_ff, rstamp_ff;
   logic        rlast_ff;

   // emission into the result register
   logic        emit;
   logic [1:0]  e_kind, e_status;
   logic [OWNER_BITS-1:0] e_owner;
   logic [63:0] e_exp;
   logic        e_last;
   logic        slot_free;

   // RAM ports
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [EW-1:0] ram_wdata, ram_rdata;
   logic [63:0]   rd_exp;

   logic [64:0] sat_sum;
   logic [63:0] period_eff;
   logic [63:0] csr_period_eff;

   assign slot_free  = !rvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rd_exp     = ram_rdata[EW-1:OWNER_BITS];
   assign sat_sum    = {1'b0, time_ff} + {1'b0, delay_ff};
   assign period_eff = (period_ff == 32'd0) ? 64'd1 : {32'd0, period_ff};
   assign csr_period_eff = (csr_wdata == 32'd0) ? 64'd1 : {32'd0, csr_wdata};

   sto_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      time_in   = time_ff;
      pcount_in = pcount_ff;
      nextp_in  = nextp_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      exp_in    = exp_ff;
      per_in    = per_ff;
      pend_in   = pend_ff;
      pdata_in  = pdata_ff;
      emit      = 1'b0;
      e_kind    = sto_pkg::KIND_DONE;
      e_status  = sto_pkg::ST_OK;
      e_owner   = '0;
      e_exp     = '0;
      e_last    = 1'b1;
      ram_we    = 1'b0;
      ram_waddr = slot(head_ff, idx_ff);
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (op_ff)
               sto_pkg::OP_REGISTER: begin
                  if (!enable_ff || count_ff == CW'(QUEUE_DEPTH)) begin
                     if (slot_free) begin
                        emit     = 1'b1;
                        e_kind   = sto_pkg::KIND_STATUS;
                        e_status = enable_ff ? sto_pkg::ST_FULL : sto_pkg::ST_DISABLED;
                        e_owner  = owner_ff;
                        state_in = S_IDLE;
                     end
                  end else begin
                     exp_in   = sat_sum[64] ? '1 : sat_sum[63:0];
                     idx_in   = count_ff;
                     state_in = S_INS_RD;
                  end
               end
               sto_pkg::OP_TICK: begin
                  if (enable_ff) begin
                     if (pcount_ff >= prescale_ff) begin
                        pcount_in = '0;
                        time_in   = time_ff + 64'd1;
                        per_in    = (time_in == nextp_ff);
                     end else begin
                        pcount_in = pcount_ff + 12'd1;
                        per_in    = 1'b0;
                     end
                     pend_in  = 1'b0;
                     state_in = S_FIRE_RD;
                  end else if (slot_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               sto_pkg::OP_CLEAR: begin
                  if (slot_free) begin
                     count_in = '0;
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  if (slot_free) begin
                     emit     = 1'b1;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         // walk from the tail towards the head, moving later entries up
         S_INS_RD: begin
            if (idx_ff == '0) begin
               state_in = S_INS_PUT;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = slot(head_ff, idx_ff - CW'(1));
               state_in  = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (rd_exp <= exp_ff) begin
               state_in = S_INS_PUT;
            end else begin
               ram_we   = 1'b1;
               idx_in   = idx_ff - CW'(1);
               state_in = S_INS_RD;
            end
         end
         S_INS_PUT: begin
            if (slot_free) begin
               ram_we    = 1'b1;
               ram_wdata = {exp_ff, owner_ff};
               count_in  = count_ff + CW'(1);
               emit      = 1'b1;
               e_kind    = sto_pkg::KIND_STATUS;
               e_owner   = owner_ff;
               e_exp     = exp_ff;
               state_in  = S_IDLE;
            end
         end
         // expiry scan from the head; one fired entry held back to set last
         S_FIRE_RD: begin
            if (count_ff == '0) begin
               state_in = S_FIRE_END;
            end else begin
               ram_re   = 1'b1;
               state_in = S_FIRE_CMP;
            end
         end
         S_FIRE_CMP: begin
            if (rd_exp > time_ff) begin
               state_in = S_FIRE_END;
            end else if (!pend_ff || slot_free) begin
               emit     = pend_ff;
               e_kind   = sto_pkg::KIND_FIRED;
               e_owner  = pdata_ff[OWNER_BITS-1:0];
               e_exp    = pdata_ff[EW-1:OWNER_BITS];
               e_last   = 1'b0;
               pend_in  = 1'b1;
               pdata_in = ram_rdata;
               head_in  = slot(head_ff, CW'(1));
               count_in = count_ff - CW'(1);
               state_in = S_FIRE_RD;
            end
         end
         S_FIRE_END: begin
            if (slot_free) begin
               emit = 1'b1;
               if (pend_ff) begin
                  e_kind  = sto_pkg::KIND_FIRED;
                  e_owner = pdata_ff[OWNER_BITS-1:0];
                  e_exp   = pdata_ff[EW-1:OWNER_BITS];
                  e_last  = !per_ff;
                  pend_in = 1'b0;
                  if (!per_ff) begin
                     state_in = S_IDLE;
                  end
               end else if (per_ff) begin
                  e_kind   = sto_pkg::KIND_PERIODIC;
                  e_exp    = nextp_ff;
                  nextp_in = nextp_ff + period_eff;
                  per_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a period write reloads the next periodic time (user writes only while idle, unchecked)
      if (csr_we && csr_index == sto_pkg::CSR_PERIOD) begin
         nextp_in = time_ff + csr_period_eff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         enable_ff   <= 1'b0;
         prescale_ff <= sto_pkg::PRESCALE_RST;
         period_ff   <= sto_pkg::PERIOD_RST;
         time_ff     <= '0;
         pcount_ff   <= '0;
         nextp_ff    <= {32'd0, sto_pkg::PERIOD_RST};
         head_ff     <= '0;
         count_ff    <= '0;
         per_ff      <= 1'b0;
         pend_ff     <= 1'b0;
         rvalid_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         time_ff   <= time_in;
         pcount_ff <= pcount_in;
         nextp_ff  <= nextp_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         per_ff    <= per_in;
         pend_ff   <= pend_in;
         if (emit) begin
            rvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rvalid_ff <= 1'b0;
         end
         // register writes; the user writes them only while idle, the block does not enforce it
         if (csr_we) begin
            case (csr_index)
               sto_pkg::CSR_ENABLE:   enable_ff   <= csr_wdata[0];
               sto_pkg::CSR_PRESCALE: prescale_ff <= csr_wdata[11:0];
               sto_pkg::CSR_PERIOD:   period_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      exp_ff   <= exp_in;
      pdata_ff <= pdata_in;
      if (req_tvalid && req_tready) begin
         op_ff    <= req_tuser;
         delay_ff <= req_tdata[63:0];
         owner_ff <= req_tdata[64 +: OWNER_BITS];
      end
      if (emit) begin
         rkind_ff  <= e_kind;
         rstat_ff  <= e_status;
         rown_ff   <= e_owner;
         rexp_ff   <= e_exp;
         rstamp_ff <= time_ff;
         rlast_ff  <= e_last;
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tuser  = rkind_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = RSP_W'({rstamp_ff, rexp_ff, rown_ff, rstat_ff});

endmodule
`default_nettype wire

@@ sv/sto_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted timer queue checker
// Port-level checks on request sequencing and result framing.
// ----------------------------------------------------------------------------
`default_nettype none
module sto_checker #(
   parameter int RSP_W = 144
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_tvalid,
   input wire logic             req_tready,
   input wire logic             rsp_tvalid,
   input wire logic             rsp_tready,
   input wire logic [1:0]       rsp_tuser,
   input wire logic [RSP_W-1:0] rsp_tdata,
   input wire logic             rsp_tlast
);

   // one request at a time: no new request straight after an accepted one
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a registration answer is always the only result of its request
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == sto_pkg::KIND_STATUS |-> rsp_tlast)
      else $error("registration status not last");

   // done and periodic results close the request and carry status ok
   a_close_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == sto_pkg::KIND_DONE || rsp_tuser == sto_pkg::KIND_PERIODIC)
      |-> rsp_tlast && rsp_tdata[1:0] == sto_pkg::ST_OK)
      else $error("closing result malformed");

endmodule

bind sorted_timer_queue sto_checker #(.RSP_W(RSP_W)) u_sto_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
